/* hdl/ufsc_pkg.sv */
// Shared types and constants for the union-find table block.
`default_nettype none
package ufsc_pkg;
   localparam int ENTRY_W = 10;
   localparam int STEP_W  = 10;

   typedef logic signed [ENTRY_W-1:0] entry_type;
   typedef logic signed [STEP_W-1:0]  step_type;

   localparam logic [1:0] ACT_LOAD  = 2'd0;
   localparam logic [1:0] ACT_UNION = 2'd1;
   localparam logic [1:0] ACT_FIND  = 2'd2;

   localparam step_type  STEP_SAT = 10'sd511;
   localparam entry_type SIZE_MIN = -10'sd512;
endpackage
`default_nettype wire

/* hdl/ufsc_table.sv */
// Parent table RAM: one write port, one read port with registered read data.
`default_nettype none
module ufsc_table #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [AW-1:0]      wr_addr,
   input  wire ufsc_pkg::entry_type wr_data,
   input  wire logic               rd_en,
   input  wire logic [AW-1:0]      rd_addr,
   output      ufsc_pkg::entry_type rd_data
);
   ufsc_pkg::entry_type mem [DEPTH];
   ufsc_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

/* hdl/union_find_size_compress_top.sv */
// Union-find table: load, union by size and find, both with path compression.
// Usage:
//   Input transactions (req_*) carry an action, two node indices and a load
//   value. A load writes one table entry and finishes at once. A union walks
//   both nodes to their roots, rewrites both paths to point at the roots and
//   links the smaller set under the larger one (first node's root wins a
//   tie). A find walks and compresses one path and returns 2*depth-1.
//   Only a find produces a response transaction (rsp_step_count); a broken
//   chain gives 511.
// Stalls: a load or an unused action leaves req_stall low. After a find is
//   accepted, req_stall stays high while it walks and compresses the path,
//   and the response is presented as it drops. A union holds it high while
//   it walks and compresses both paths and, if the roots differ, links them;
//   a broken chain ends early. The single table RAM does at most one read
//   and one write per cycle; a path step writes only while compressing.
// Throughput: one transaction at a time; req_stall is high while one is in
//   progress. A finished result sits in an output register, so a stalled
//   response only holds the block until the next find result is ready.
// Reset clears the sequencer and the response valid; the table contents are
//   undefined until loaded and are not cleared.
`default_nettype none
module union_find_size_compress_top #(
   parameter int NUM_NODES = 256
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire logic [1:0]             req_action,
   input  wire logic [7:0]             req_node_a,
   input  wire logic [7:0]             req_node_b,
   input  wire logic signed [8:0]      req_entry_value,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      ufsc_pkg::step_type     rsp_step_count
);
   localparam int AW = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
   localparam int DW = $clog2(NUM_NODES + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_WALK,
      S_CSTART,
      S_COMPRESS,
      S_LINK_ROOT,
      S_LINK_CHILD,
      S_OUT
   } state_type;

   state_type           state_ff, state_in;
   logic [AW-1:0]       cur_ff, cur_in;
   logic [DW-1:0]       depth_ff, depth_in;
   logic [AW-1:0]       ra_ff, ra_in, rb_ff, rb_in;
   ufsc_pkg::entry_type va_ff, va_in, vb_ff, vb_in;
   logic                phase_b_ff, phase_b_in;
   logic                is_union_ff, is_union_in;
   logic [7:0]          node_a_ff, node_a_in, node_b_ff, node_b_in;
   ufsc_pkg::step_type  count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   ufsc_pkg::step_type  rsp_count_ff, rsp_count_in;

   logic                mem_we, mem_re;
   logic [AW-1:0]       mem_waddr, mem_raddr;
   ufsc_pkg::entry_type mem_wdata, rdata;

   logic [AW-1:0]       root_sel, winner, loser, next_idx;
   logic signed [10:0]  size_sum;
   ufsc_pkg::entry_type size_sat;
   ufsc_pkg::step_type  depth_count;
   logic                a_in_range, b_in_range;

   ufsc_table #(.DEPTH(NUM_NODES), .AW(AW)) u_table (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (rdata)
   );

   always_comb begin
      root_sel   = phase_b_ff ? rb_ff : ra_ff;
      winner     = (va_ff <= vb_ff) ? ra_ff : rb_ff;
      loser      = (va_ff <= vb_ff) ? rb_ff : ra_ff;
      next_idx   = AW'($unsigned(rdata));
      size_sum   = {va_ff[9], va_ff} + {vb_ff[9], vb_ff};
      size_sat   = (size_sum < -11'sd512) ? ufsc_pkg::SIZE_MIN : size_sum[9:0];
      a_in_range = int'(req_node_a) < NUM_NODES;
      b_in_range = int'(node_b_ff) < NUM_NODES;
      if (int'(depth_ff) >= 256) begin
         depth_count = ufsc_pkg::STEP_SAT;
      end else begin
         depth_count = (10'(depth_ff) << 1) - 10'sd1;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      depth_in     = depth_ff;
      ra_in        = ra_ff;
      rb_in        = rb_ff;
      va_in        = va_ff;
      vb_in        = vb_ff;
      phase_b_in   = phase_b_ff;
      is_union_in  = is_union_ff;
      node_a_in    = node_a_ff;
      node_b_in    = node_b_ff;
      count_in     = count_ff;
      rsp_count_in = rsp_count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_we       = 1'b0;
      mem_waddr    = cur_ff;
      mem_wdata    = ufsc_pkg::ENTRY_W'(root_sel);
      mem_re       = 1'b0;
      mem_raddr    = cur_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               node_a_in   = req_node_a;
               node_b_in   = req_node_b;
               is_union_in = (req_action == ufsc_pkg::ACT_UNION);
               case (req_action)
                  ufsc_pkg::ACT_LOAD: begin
                     if (a_in_range) begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(req_node_a);
                        mem_wdata = {req_entry_value[8], req_entry_value};
                     end
                  end
                  ufsc_pkg::ACT_UNION, ufsc_pkg::ACT_FIND: begin
                     if (!a_in_range) begin
                        if (req_action == ufsc_pkg::ACT_FIND) begin
                           count_in = ufsc_pkg::STEP_SAT;
                           state_in = S_OUT;
                        end
                     end else begin
                        cur_in     = AW'(req_node_a);
                        depth_in   = '0;
                        phase_b_in = 1'b0;
                        mem_re     = 1'b1;
                        mem_raddr  = AW'(req_node_a);
                        state_in   = S_WALK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_WALK: begin
            if (rdata[9]) begin
               if (!phase_b_ff) begin
                  ra_in    = cur_ff;
                  va_in    = rdata;
                  count_in = depth_count;
               end else begin
                  rb_in = cur_ff;
                  vb_in = rdata;
               end
               if (is_union_ff && !phase_b_ff) begin
                  if (!b_in_range) begin
                     state_in = S_IDLE;
                  end else begin
                     cur_in     = AW'(node_b_ff);
                     depth_in   = '0;
                     phase_b_in = 1'b1;
                     mem_re     = 1'b1;
                     mem_raddr  = AW'(node_b_ff);
                  end
               end else begin
                  cur_in     = AW'(node_a_ff);
                  phase_b_in = 1'b0;
                  state_in   = S_CSTART;
               end
            end else if (int'(depth_ff) >= NUM_NODES || int'(rdata) >= NUM_NODES) begin
               if (is_union_ff) begin
                  state_in = S_IDLE;
               end else begin
                  count_in = ufsc_pkg::STEP_SAT;
                  state_in = S_OUT;
               end
            end else begin
               cur_in    = next_idx;
               depth_in  = depth_ff + DW'(1);
               mem_re    = 1'b1;
               mem_raddr = next_idx;
            end
         end
         S_CSTART: begin
            if (cur_ff == root_sel) begin
               if (is_union_ff && !phase_b_ff) begin
                  phase_b_in = 1'b1;
                  cur_in     = AW'(node_b_ff);
               end else if (is_union_ff) begin
                  state_in = (ra_ff == rb_ff) ? S_IDLE : S_LINK_ROOT;
               end else begin
                  state_in = S_OUT;
               end
            end else begin
               mem_re    = 1'b1;
               mem_raddr = cur_ff;
               state_in  = S_COMPRESS;
            end
         end
         S_COMPRESS: begin
            mem_we    = 1'b1;
            mem_waddr = cur_ff;
            mem_wdata = ufsc_pkg::ENTRY_W'(root_sel);
            cur_in    = next_idx;
            if (next_idx == root_sel) begin
               state_in = S_CSTART;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = next_idx;
            end
         end
         S_LINK_ROOT: begin
            mem_we    = 1'b1;
            mem_waddr = winner;
            mem_wdata = size_sat;
            state_in  = S_LINK_CHILD;
         end
         S_LINK_CHILD: begin
            mem_we    = 1'b1;
            mem_waddr = loser;
            mem_wdata = ufsc_pkg::ENTRY_W'(winner);
            state_in  = S_IDLE;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = count_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff       <= cur_in;
      depth_ff     <= depth_in;
      ra_ff        <= ra_in;
      rb_ff        <= rb_in;
      va_ff        <= va_in;
      vb_ff        <= vb_in;
      phase_b_ff   <= phase_b_in;
      is_union_ff  <= is_union_in;
      node_a_ff    <= node_a_in;
      node_b_ff    <= node_b_in;
      count_ff     <= count_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_step_count = rsp_count_ff;
endmodule
`default_nettype wire
